/* rtl/bcrm_pkg.sv */
package bcrm_pkg;

  // Sizes of the instruction and result fields
  localparam int MAX_REGS    = 64;
  localparam int CMD_W       = 4;
  localparam int IDX_W       = 6;
  localparam int DATA_W      = 64;
  localparam int CNT_W       = 7;
  localparam int STATUS_W    = 3;
  localparam int MSTATE_W    = 2;
  localparam int QUEUE_DEPTH = 2;

  // Stream and configuration port widths
  localparam int IN_TDATA_W  = 88;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 72;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  // Register map
  localparam logic [APB_AW-3:0] REG_COUNT_IDX = '0;
  localparam logic [CNT_W-1:0]  REG_COUNT_RST = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 4'd0,
    CMD_ADD32  = 4'd1,
    CMD_ADD64  = 4'd2,
    CMD_MUL32  = 4'd3,
    CMD_MUL64  = 4'd4,
    CMD_MIN32  = 4'd5,
    CMD_MIN64  = 4'd6,
    CMD_MAX32  = 4'd7,
    CMD_MAX64  = 4'd8,
    CMD_COPY   = 4'd9,
    CMD_LIMM   = 4'd10,
    CMD_ASSERT = 4'd11,
    CMD_RETURN = 4'd12
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK          = 3'd0,
    STS_FINISHED    = 3'd1,
    STS_ASSERT_FAIL = 3'd2,
    STS_UNKNOWN_CMD = 3'd3,
    STS_BAD_INDEX   = 3'd4,
    STS_NOT_RUNNING = 3'd5
  } status_e;

  typedef enum logic [MSTATE_W-1:0] {
    MS_IDLE  = 2'd0,
    MS_RUN   = 2'd1,
    MS_HALT  = 2'd2,
    MS_FINAL = 2'd3
  } mstate_e;

  // Instruction class as seen by the execute side
  typedef enum logic [2:0] {
    K_START,
    K_ARITH,
    K_COPY,
    K_LIMM,
    K_ASSERT,
    K_RETURN,
    K_UNKNOWN
  } kind_e;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_MUL,
    OP_MIN,
    OP_MAX
  } alu_op_e;

  // Classified instruction carried through the queue
  typedef struct packed {
    kind_e             kind;
    alu_op_e           op;
    logic              is32;
    logic              idx_bad;
    logic [IDX_W-1:0]  dst;
    logic [IDX_W-1:0]  src_a;
    logic [IDX_W-1:0]  src_b;
    logic [DATA_W-1:0] imm;
  } instr_t;

  // Sign-extend the low half of a word
  function automatic logic [DATA_W-1:0] sext32(input logic [DATA_W-1:0] v);
    return {{(DATA_W/2){v[DATA_W/2-1]}}, v[DATA_W/2-1:0]};
  endfunction

endpackage

/* rtl/bcrm_ram.sv */
module bcrm_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                    wdata_i,
  input  logic                                re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                    rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port, registered read port (read returns the old contents)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bcrm_queue.sv */
module bcrm_queue #(
  parameter int Depth = bcrm_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bcrm_pkg::instr_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output bcrm_pkg::instr_t data_o
);
  import bcrm_pkg::*;

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  instr_t          entry_q [Depth];
  logic [PW-1:0]   wptr_q, wptr_d;
  logic [PW-1:0]   rptr_q, rptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Hold entries until popped
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= data_i;
    end
  end

endmodule

/* rtl/bcrm_front.sv */
module bcrm_front #(
  parameter int MaxRegs = bcrm_pkg::MAX_REGS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bcrm_pkg::APB_AW-1:0]       paddr,
  input  logic [bcrm_pkg::APB_DW-1:0]       pwdata,
  output logic [bcrm_pkg::APB_DW-1:0]       prdata,
  output logic                              pready,
  // Instruction stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bcrm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic [bcrm_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  // Queue side
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output bcrm_pkg::instr_t                  q_instr_o
);
  import bcrm_pkg::*;

  logic [CNT_W-1:0] reg_count_q;
  logic             reg_hit;
  logic [IDX_W-1:0] dst, src_a, src_b;
  logic             ok_d, ok_a, ok_b;

  // Register write on the access phase
  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_AW-1:2] == REG_COUNT_IDX);
  assign prdata  = reg_hit ? APB_DW'(reg_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_count_q <= REG_COUNT_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      reg_count_q <= pwdata[CNT_W-1:0];
    end
  end

  // Unpack the word and check indexes against the usable register count
  assign dst   = s_axis_tdata[IDX_W-1:0];
  assign src_a = s_axis_tdata[2*IDX_W-1:IDX_W];
  assign src_b = s_axis_tdata[3*IDX_W-1:2*IDX_W];

  assign ok_d = ({1'b0, dst}   < reg_count_q) && (32'(dst)   < MaxRegs);
  assign ok_a = ({1'b0, src_a} < reg_count_q) && (32'(src_a) < MaxRegs);
  assign ok_b = ({1'b0, src_b} < reg_count_q) && (32'(src_b) < MaxRegs);

  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i;

  // Classify the command
  always_comb begin
    q_instr_o         = '0;
    q_instr_o.dst     = dst;
    q_instr_o.src_a   = src_a;
    q_instr_o.src_b   = src_b;
    q_instr_o.imm     = s_axis_tdata[3*IDX_W+DATA_W-1:3*IDX_W];
    q_instr_o.op      = OP_ADD;
    q_instr_o.is32    = 1'b0;
    q_instr_o.idx_bad = !(ok_d && ok_a && ok_b);
    case (cmd_e'(s_axis_tuser))
      CMD_START: begin
        q_instr_o.kind = K_START;
      end
      CMD_ADD32, CMD_ADD64: begin
        q_instr_o.kind = K_ARITH;
        q_instr_o.op   = OP_ADD;
        q_instr_o.is32 = (cmd_e'(s_axis_tuser) == CMD_ADD32);
      end
      CMD_MUL32, CMD_MUL64: begin
        q_instr_o.kind = K_ARITH;
        q_instr_o.op   = OP_MUL;
        q_instr_o.is32 = (cmd_e'(s_axis_tuser) == CMD_MUL32);
      end
      CMD_MIN32, CMD_MIN64: begin
        q_instr_o.kind = K_ARITH;
        q_instr_o.op   = OP_MIN;
        q_instr_o.is32 = (cmd_e'(s_axis_tuser) == CMD_MIN32);
      end
      CMD_MAX32, CMD_MAX64: begin
        q_instr_o.kind = K_ARITH;
        q_instr_o.op   = OP_MAX;
        q_instr_o.is32 = (cmd_e'(s_axis_tuser) == CMD_MAX32);
      end
      CMD_COPY: begin
        q_instr_o.kind    = K_COPY;
        q_instr_o.idx_bad = !(ok_d && ok_a);
      end
      CMD_LIMM: begin
        q_instr_o.kind    = K_LIMM;
        q_instr_o.idx_bad = !ok_d;
      end
      CMD_ASSERT: begin
        q_instr_o.kind    = K_ASSERT;
        q_instr_o.idx_bad = !ok_d;
      end
      CMD_RETURN: begin
        q_instr_o.kind = K_RETURN;
      end
      default: begin
        q_instr_o.kind = K_UNKNOWN;
      end
    endcase
  end

endmodule

/* rtl/bcrm_back.sv */
module bcrm_back #(
  parameter int MaxRegs = bcrm_pkg::MAX_REGS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Queue side
  input  logic                            q_valid_i,
  input  bcrm_pkg::instr_t                q_instr_i,
  output logic                            q_pop_o,
  // Result side
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bcrm_pkg::STATUS_W-1:0]   status_o,
  output logic                            dest_written_o,
  output logic [bcrm_pkg::DATA_W-1:0]     written_value_o,
  output logic [bcrm_pkg::MSTATE_W-1:0]   machine_state_o
);
  import bcrm_pkg::*;

  localparam int AW = (MaxRegs > 1) ? $clog2(MaxRegs) : 1;
  localparam int HW = DATA_W / 2;

  logic adv;

  // Read stage
  logic [IDX_W-1:0]  rd0_idx, rd1_idx;
  logic [DATA_W-1:0] rdata0, rdata1;
  logic [MaxRegs-1:0] valid_q;
  logic              vld0_q, vld1_q;

  // Execute stage one
  logic              ex1_valid_q;
  instr_t            ex1_q;
  mstate_e           state_q, state_d;
  logic [IDX_W-1:0]  p0_idx;
  logic [DATA_W-1:0] x, y, xs, ys, sum, alu, alu_fin;
  logic              lt;
  status_e           status_d;
  logic              wr_d, start_d, mul_d;
  logic [DATA_W-1:0] val_d;
  logic [DATA_W-1:0] pll_d;
  logic [HW-1:0]     plh_d, phl_d;

  // Execute stage two
  logic              ex2_valid_q;
  logic              ex2_start_q, ex2_wr_q, ex2_mul_q, ex2_is32_q;
  logic [IDX_W-1:0]  ex2_dst_q;
  status_e           ex2_status_q;
  mstate_e           ex2_state_q;
  logic [DATA_W-1:0] ex2_val_q, ex2_pll_q;
  logic [HW-1:0]     ex2_plh_q, ex2_phl_q, mul_hi;
  logic [DATA_W-1:0] ex2_result;

  // Last committed write, for reads issued in the same cycle
  logic              wb_valid_q, wb_start_q;
  logic [IDX_W-1:0]  wb_dst_q;
  logic [DATA_W-1:0] wb_val_q;

  // Output register
  logic              out_valid_q;
  status_e           out_status_q;
  logic              out_wr_q;
  logic [DATA_W-1:0] out_val_q;
  mstate_e           out_state_q;

  // Resolve an operand: newest write first, cleared file after a start
  function automatic logic [DATA_W-1:0] pick(
    input logic [IDX_W-1:0]  idx,
    input logic [DATA_W-1:0] ram,
    input logic              vld,
    input logic              e2v,
    input logic              e2s,
    input logic              e2w,
    input logic [IDX_W-1:0]  e2d,
    input logic [DATA_W-1:0] e2val,
    input logic              wbv,
    input logic              wbs,
    input logic [IDX_W-1:0]  wbd,
    input logic [DATA_W-1:0] wbval
  );
    logic [DATA_W-1:0] r;
    if (e2v && e2s) begin
      r = '0;
    end else if (e2v && e2w && (e2d == idx)) begin
      r = e2val;
    end else if (wbv && wbs) begin
      r = '0;
    end else if (wbv && (wbd == idx)) begin
      r = wbval;
    end else if (vld) begin
      r = ram;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  // The whole execute pipe moves when the output register can take a word
  assign adv     = !out_valid_q || out_ready_i;
  assign q_pop_o = adv && q_valid_i;

  assign rd0_idx = (q_instr_i.kind == K_ASSERT) ? q_instr_i.dst : q_instr_i.src_a;
  assign rd1_idx = q_instr_i.src_b;

  // Two copies of the register file give two read ports
  bcrm_ram #(
    .Width(DATA_W),
    .Depth(MaxRegs)
  ) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (adv && ex2_valid_q && ex2_wr_q),
    .waddr_i(AW'(ex2_dst_q)),
    .wdata_i(ex2_result),
    .re_i   (q_pop_o),
    .raddr_i(AW'(rd0_idx)),
    .rdata_o(rdata0)
  );

  bcrm_ram #(
    .Width(DATA_W),
    .Depth(MaxRegs)
  ) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (adv && ex2_valid_q && ex2_wr_q),
    .waddr_i(AW'(ex2_dst_q)),
    .wdata_i(ex2_result),
    .re_i   (q_pop_o),
    .raddr_i(AW'(rd1_idx)),
    .rdata_o(rdata1)
  );

  // Finish the multiply and select the value written in stage two
  assign mul_hi = ex2_plh_q + ex2_phl_q + ex2_pll_q[DATA_W-1:HW];

  always_comb begin
    if (!ex2_wr_q) begin
      ex2_result = '0;
    end else if (ex2_mul_q) begin
      ex2_result = ex2_is32_q ? sext32(ex2_pll_q) : {mul_hi, ex2_pll_q[HW-1:0]};
    end else begin
      ex2_result = ex2_val_q;
    end
  end

  // Operands with forwarding
  assign p0_idx = (ex1_q.kind == K_ASSERT) ? ex1_q.dst : ex1_q.src_a;

  assign x = pick(p0_idx, rdata0, vld0_q, ex2_valid_q, ex2_start_q, ex2_wr_q, ex2_dst_q,
                  ex2_result, wb_valid_q, wb_start_q, wb_dst_q, wb_val_q);
  assign y = pick(ex1_q.src_b, rdata1, vld1_q, ex2_valid_q, ex2_start_q, ex2_wr_q, ex2_dst_q,
                  ex2_result, wb_valid_q, wb_start_q, wb_dst_q, wb_val_q);

  // Arithmetic; multiply is split into half-word products
  assign xs  = ex1_q.is32 ? sext32(x) : x;
  assign ys  = ex1_q.is32 ? sext32(y) : y;
  assign sum = xs + ys;
  assign lt  = ($signed(xs) < $signed(ys));

  assign pll_d = DATA_W'(xs[HW-1:0]) * DATA_W'(ys[HW-1:0]);
  assign plh_d = xs[HW-1:0] * ys[DATA_W-1:HW];
  assign phl_d = xs[DATA_W-1:HW] * ys[HW-1:0];

  always_comb begin
    case (ex1_q.op)
      OP_ADD:  alu = sum;
      OP_MIN:  alu = lt ? xs : ys;
      OP_MAX:  alu = lt ? ys : xs;
      default: alu = '0;
    endcase
  end

  assign alu_fin = ex1_q.is32 ? sext32(alu) : alu;

  // Carry out the instruction against the run state
  always_comb begin
    status_d = STS_OK;
    wr_d     = 1'b0;
    start_d  = 1'b0;
    mul_d    = 1'b0;
    val_d    = '0;
    state_d  = state_q;
    if (ex1_q.kind == K_START) begin
      start_d = 1'b1;
      state_d = MS_RUN;
    end else if (state_q != MS_RUN) begin
      status_d = STS_NOT_RUNNING;
    end else begin
      case (ex1_q.kind)
        K_ARITH, K_COPY, K_LIMM: begin
          if (ex1_q.idx_bad) begin
            status_d = STS_BAD_INDEX;
            state_d  = MS_HALT;
          end else begin
            wr_d = 1'b1;
            if (ex1_q.kind == K_ARITH) begin
              val_d = alu_fin;
              mul_d = (ex1_q.op == OP_MUL);
            end else if (ex1_q.kind == K_COPY) begin
              val_d = x;
            end else begin
              val_d = ex1_q.imm;
            end
          end
        end
        K_ASSERT: begin
          if (ex1_q.idx_bad) begin
            status_d = STS_BAD_INDEX;
            state_d  = MS_HALT;
          end else if (x == '0) begin
            status_d = STS_ASSERT_FAIL;
            state_d  = MS_HALT;
          end
        end
        K_RETURN: begin
          status_d = STS_FINISHED;
          state_d  = MS_FINAL;
        end
        default: begin
          status_d = STS_UNKNOWN_CMD;
          state_d  = MS_HALT;
        end
      endcase
    end
  end

  // Control state of the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex1_valid_q <= 1'b0;
      ex2_valid_q <= 1'b0;
      wb_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= MS_IDLE;
      valid_q     <= '0;
    end else if (adv) begin
      ex1_valid_q <= q_valid_i;
      ex2_valid_q <= ex1_valid_q;
      wb_valid_q  <= ex2_valid_q && (ex2_wr_q || ex2_start_q);
      out_valid_q <= ex2_valid_q;
      if (ex1_valid_q) begin
        state_q <= state_d;
      end
      // Drop every entry on start, mark the entry on a write
      if (ex2_valid_q && ex2_start_q) begin
        valid_q <= '0;
      end else if (ex2_valid_q && ex2_wr_q) begin
        valid_q[AW'(ex2_dst_q)] <= 1'b1;
      end
    end
  end

  // Payload of the pipe
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      vld0_q <= valid_q[AW'(rd0_idx)];
      vld1_q <= valid_q[AW'(rd1_idx)];
    end
    if (adv) begin
      ex1_q        <= q_instr_i;
      ex2_start_q  <= start_d;
      ex2_wr_q     <= wr_d;
      ex2_mul_q    <= mul_d;
      ex2_is32_q   <= ex1_q.is32;
      ex2_dst_q    <= ex1_q.dst;
      ex2_status_q <= status_d;
      ex2_state_q  <= state_d;
      ex2_val_q    <= val_d;
      ex2_pll_q    <= pll_d;
      ex2_plh_q    <= plh_d;
      ex2_phl_q    <= phl_d;
      wb_start_q   <= ex2_start_q;
      wb_dst_q     <= ex2_dst_q;
      wb_val_q     <= ex2_result;
      out_status_q <= ex2_status_q;
      out_wr_q     <= ex2_wr_q;
      out_val_q    <= ex2_result;
      out_state_q  <= ex2_state_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign dest_written_o  = out_wr_q;
  assign written_value_o = out_val_q;
  assign machine_state_o = out_state_q;

endmodule

/* rtl/bytecode_register_machine_exec_top.sv */
// A word accepted on the instruction stream reaches the result stream through the instruction
// queue, register read and execute, multiply finish and result register. Throughput: one
// instruction per cycle while the result stream is ready; a dependent result is forwarded.
// Register reads use two copies of the register file, each one read port, with a valid bit
// per entry so a start clears the file at once. Reset (rst_ni low, asynchronous) empties
// the pipe, sets the machine idle, clears the file and sets reg_count to 64.
module bytecode_register_machine_exec_top #(
  parameter int MaxRegs = bcrm_pkg::MAX_REGS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bcrm_pkg::APB_AW-1:0]      paddr,
  input  logic [bcrm_pkg::APB_DW-1:0]      pwdata,
  output logic [bcrm_pkg::APB_DW-1:0]      prdata,
  output logic                             pready,
  // Instruction stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // dst_index[5:0], src_a_index[11:6], src_b_index[17:12], immediate[81:18], zero[87:82]
  input  logic [bcrm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // command[3:0]
  input  logic [bcrm_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  // Result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status[2:0], dest_written[3], written_value[67:4], machine_state[69:68], zero[71:70]
  output logic [bcrm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import bcrm_pkg::*;

  logic              q_full, q_push, q_valid, q_pop;
  instr_t            q_in, q_out;
  logic [STATUS_W-1:0] status;
  logic              dest_written;
  logic [DATA_W-1:0] written_value;
  logic [MSTATE_W-1:0] machine_state;

  bcrm_front #(
    .MaxRegs(MaxRegs)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_instr_o    (q_in)
  );

  bcrm_queue #(
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_out)
  );

  bcrm_back #(
    .MaxRegs(MaxRegs)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_instr_i      (q_out),
    .q_pop_o        (q_pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .status_o       (status),
    .dest_written_o (dest_written),
    .written_value_o(written_value),
    .machine_state_o(machine_state)
  );

  // Pack the result word
  assign m_axis_tdata = {
    {(OUT_TDATA_W - STATUS_W - 1 - DATA_W - MSTATE_W){1'b0}},
    machine_state, written_value, dest_written, status
  };

endmodule
